[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the escape-time block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the active-low reset is asserted.
`define ASSERT_RST(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check on the block's standard clock and reset.
`define ASSERT_STD(name, prop, msg) \
  `ASSERT_RST(name, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/mep_pkg.sv]
// Shared constants, codes and controller/datapath interface types of the escape-time block.
package mep_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int FRACTION_BITS = 28;
  localparam int Z_INT_BITS    = 12;
  localparam int Z_BITS        = FRACTION_BITS + Z_INT_BITS;
  localparam int HALF_BITS     = (Z_BITS + 1) / 2;
  localparam int PROD_BITS     = 4 * HALF_BITS;
  localparam int C_BITS        = 32;
  localparam int C_FRAC        = 28;
  localparam int BOUND_BITS    = 32;
  localparam int BOUND_FRAC    = 27;
  localparam int ADDR_BITS     = 4;

  // Three products of four half-width partials each.
  localparam int MUL_STEPS     = 12;
  localparam int STEP_BITS     = 4;

  localparam logic [1:0] MODE_BW    = 2'd0;
  localparam logic [1:0] MODE_GREY  = 2'd1;
  localparam logic [1:0] MODE_COLOR = 2'd2;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_BOUND      = 2'd1;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd2;
  localparam logic [1:0] REG_COLOR_STEP = 2'd3;

  localparam logic [1:0]             MODE_RESET       = MODE_GREY;
  localparam logic [BOUND_BITS-1:0]  BOUND_RESET      = 32'd536870912;
  localparam logic [COUNT_WIDTH-1:0] ITER_LIMIT_RESET = COUNT_WIDTH'(255);
  localparam logic [7:0]             COLOR_STEP_RESET = 8'd1;

  typedef struct packed {
    logic                 load;
    logic                 issue;
    logic [STEP_BITS-1:0] step;
    logic                 check;
    logic                 update;
    logic                 emit;
    logic                 in_set;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic escape;
  } sts_t;

endpackage

[rtl/core/mep_ctrl.sv]
// Sequencer of the escape-time iteration: issues multiply, check and update steps.
module mep_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_free_i,
  input  mep_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output mep_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_DRAIN,
    ST_CHECK,
    ST_UPDATE,
    ST_FINISH
  } state_e;

  state_e                        state_q;
  logic [mep_pkg::STEP_BITS-1:0] step_q;
  logic                          in_set_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      in_set_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_TEST;
          end
        end
        ST_TEST: begin
          if (sts_i.count_zero) begin
            in_set_q <= 1'b1;
            state_q  <= ST_FINISH;
          end else begin
            step_q  <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (step_q == mep_pkg::STEP_BITS'(mep_pkg::MUL_STEPS - 1)) begin
            step_q  <= '0;
            state_q <= ST_DRAIN;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sts_i.escape) begin
            in_set_q <= 1'b0;
            state_q  <= ST_FINISH;
          end else begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_q <= ST_TEST;
        end
        ST_FINISH: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue  = (state_q == ST_MUL);
    cmd_o.step   = step_q;
    cmd_o.check  = (state_q == ST_CHECK);
    cmd_o.update = (state_q == ST_UPDATE);
    cmd_o.emit   = (state_q == ST_FINISH) && out_free_i;
    cmd_o.in_set = in_set_q;
  end

endmodule

[rtl/core/mep_datapath.sv]
// Fixed-point datapath: shared half-width multiplier, accumulator, escape test and z update.
module mep_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mep_pkg::cmd_t                       cmd_i,
  input  logic [mep_pkg::COUNT_WIDTH-1:0]     iter_limit_i,
  input  logic [mep_pkg::BOUND_BITS-1:0]      bound_i,
  input  logic signed [mep_pkg::C_BITS-1:0]   c_real_i,
  input  logic signed [mep_pkg::C_BITS-1:0]   c_imag_i,
  output mep_pkg::sts_t                       sts_o,
  output logic [mep_pkg::COUNT_WIDTH-1:0]     count_o
);

  localparam int ZB     = mep_pkg::Z_BITS;
  localparam int HB     = mep_pkg::HALF_BITS;
  localparam int PB     = mep_pkg::PROD_BITS;
  localparam int RW     = PB + 1;
  localparam int EXTW   = (RW > 64) ? RW : 64;
  localparam int CEW    = mep_pkg::C_BITS + mep_pkg::FRACTION_BITS;
  localparam int MSHIFT = 2 * mep_pkg::FRACTION_BITS - mep_pkg::BOUND_FRAC;

  // Clamp a wide signed value to the z range.
  function automatic logic [ZB-1:0] sat_z(input logic [RW-1:0] v);
    logic hi_any;
    logic hi_all;
    hi_any = |v[RW-2:ZB-1];
    hi_all = &v[RW-2:ZB-1];
    if (!v[RW-1] && hi_any) begin
      sat_z = {1'b0, {(ZB-1){1'b1}}};
    end else if (v[RW-1] && !hi_all) begin
      sat_z = {1'b1, {(ZB-1){1'b0}}};
    end else begin
      sat_z = v[ZB-1:0];
    end
  endfunction

  logic [ZB-1:0]                   cr_q, ci_q, zr_q, zi_q, re_q, im_q;
  logic [mep_pkg::COUNT_WIDTH-1:0] count_q;
  logic [PB-1:0]                   acc_q, sq_r_q, sq_i_q, xp_q;
  logic [2*HB-1:0]                 prod_q;
  logic [mep_pkg::STEP_BITS-1:0]   ptag_q;
  logic                            pv_q;

  // Convert c to z format, flooring when the z fraction is narrower.
  logic signed [CEW-1:0] crw, ciw, crs, cis;
  always_comb begin
    crw = CEW'(c_real_i) <<< mep_pkg::FRACTION_BITS;
    ciw = CEW'(c_imag_i) <<< mep_pkg::FRACTION_BITS;
    crs = crw >>> mep_pkg::C_FRAC;
    cis = ciw >>> mep_pkg::C_FRAC;
  end

  // Operand magnitudes, padded to two halves.
  logic [2*HB-1:0] mag_r, mag_i, op_a, op_b;
  logic [HB-1:0]   half_a, half_b;
  logic [1:0]      sel, part;
  assign mag_r = (2*HB)'(zr_q[ZB-1] ? (~zr_q + 1'b1) : zr_q);
  assign mag_i = (2*HB)'(zi_q[ZB-1] ? (~zi_q + 1'b1) : zi_q);
  assign sel    = cmd_i.step[3:2];
  assign part   = cmd_i.step[1:0];
  assign op_a   = (sel == 2'd1) ? mag_i : mag_r;
  assign op_b   = (sel == 2'd0) ? mag_r : mag_i;
  assign half_a = part[1] ? op_a[2*HB-1:HB] : op_a[HB-1:0];
  assign half_b = part[0] ? op_b[2*HB-1:HB] : op_b[HB-1:0];

  // Align the registered partial product.
  logic [PB-1:0] term, acc_sum;
  always_comb begin
    case (ptag_q[1:0])
      2'd0:    term = PB'(prod_q);
      2'd3:    term = PB'(prod_q) << (2*HB);
      default: term = PB'(prod_q) << HB;
    endcase
  end
  assign acc_sum = acc_q + term;

  // Escape test and next z terms.
  logic [RW-1:0]   msum, diff, xs, re_sh, im_sh, zr_sum, zi_sum;
  logic [EXTW-1:0] m_ext;
  logic            xneg;
  assign msum  = {1'b0, sq_r_q} + {1'b0, sq_i_q};
  assign m_ext = EXTW'(msum) >> MSHIFT;
  assign diff  = {1'b0, sq_r_q} - {1'b0, sq_i_q};
  assign xneg  = zr_q[ZB-1] ^ zi_q[ZB-1];
  assign xs    = xneg ? (~{1'b0, xp_q} + 1'b1) : {1'b0, xp_q};
  assign re_sh = RW'($signed(diff) >>> mep_pkg::FRACTION_BITS);
  assign im_sh = RW'($signed(xs) >>> (mep_pkg::FRACTION_BITS - 1));
  assign zr_sum = RW'($signed(re_q)) + RW'($signed(cr_q));
  assign zi_sum = RW'($signed(im_q)) + RW'($signed(ci_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q    <= ZB'(crs);
      ci_q    <= ZB'(cis);
      zr_q    <= '0;
      zi_q    <= '0;
      count_q <= iter_limit_i;
      acc_q   <= '0;
    end
    if (cmd_i.issue) begin
      prod_q <= half_a * half_b;
      ptag_q <= cmd_i.step;
    end
    if (pv_q) begin
      if (ptag_q[1:0] == 2'd3) begin
        acc_q <= '0;
        case (ptag_q[3:2])
          2'd0:    sq_r_q <= acc_sum;
          2'd1:    sq_i_q <= acc_sum;
          default: xp_q   <= acc_sum;
        endcase
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (cmd_i.check) begin
      re_q <= sat_z(re_sh);
      im_q <= sat_z(im_sh);
    end
    if (cmd_i.update) begin
      zr_q    <= sat_z(zr_sum);
      zi_q    <= sat_z(zi_sum);
      count_q <= count_q - 1'b1;
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.escape     = (m_ext[63:0] >= 64'(bound_i));
  assign count_o          = count_q;

endmodule

[rtl/core/mandelbrot_escape_pixel.sv]
// Top level of the escape-time pixel evaluator: register port, sequencer, datapath, output stage.
//
// Usage:
//   Input channel: present c_real_i / c_imag_i (signed Q4.28) with in_valid_i; a transfer
//   happens on a clock edge with in_valid_i high and in_stall_o low. One point is worked
//   on at a time; in_stall_o stays high from the transfer until the result is loaded.
//   Output channel: out_valid_o with escape_count_o, in_set_o and the pixel bytes
//   grey_o / red_o / green_o / blue_o; a transfer happens when out_stall_i is low.
//   Each test of |z|^2 runs through the single shared half-width multiplier, which forms
//   the three products as twelve partial products in sequence; drain, check and update
//   states follow before the next test. A point that escapes finishes at its check; a
//   point in the set finishes at the test that finds its iteration limit used up.
//   A finished result sits in the output register, so the next point is taken while it
//   waits; the sequencer holds in its finish state only if the previous result is still
//   stalled when the new one is ready.
//   Reset clears the handshake state and loads the register defaults: greyscale mode,
//   bound 4.0, iteration limit 255, color step 1. Write registers only while idle.
`include "assert_macros.svh"

module mandelbrot_escape_pixel (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // point input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [mep_pkg::C_BITS-1:0] c_real_i,
  input  logic signed [mep_pkg::C_BITS-1:0] c_imag_i,
  // result output
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [15:0]                      escape_count_o,
  output logic                             in_set_o,
  output logic [7:0]                       grey_o,
  output logic [7:0]                       red_o,
  output logic [7:0]                       green_o,
  output logic [7:0]                       blue_o,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mep_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // Configuration registers.
  logic [1:0]                      mode_q;
  logic [mep_pkg::BOUND_BITS-1:0]  bound_q;
  logic [mep_pkg::COUNT_WIDTH-1:0] iter_limit_q;
  logic [7:0]                      color_step_q;
  logic                            cfg_wr;
  logic [1:0]                      reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mep_pkg::MODE_RESET;
      bound_q      <= mep_pkg::BOUND_RESET;
      iter_limit_q <= mep_pkg::ITER_LIMIT_RESET;
      color_step_q <= mep_pkg::COLOR_STEP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        mep_pkg::REG_MODE:       mode_q       <= pwdata[1:0];
        mep_pkg::REG_BOUND:      bound_q      <= pwdata;
        mep_pkg::REG_ITER_LIMIT: iter_limit_q <= pwdata[mep_pkg::COUNT_WIDTH-1:0];
        mep_pkg::REG_COLOR_STEP: color_step_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mep_pkg::REG_MODE:       prdata = {30'b0, mode_q};
      mep_pkg::REG_BOUND:      prdata = bound_q;
      mep_pkg::REG_ITER_LIMIT: prdata = 32'(iter_limit_q);
      mep_pkg::REG_COLOR_STEP: prdata = {24'b0, color_step_q};
      default:                 prdata = '0;
    endcase
  end

  // Sequencer and datapath.
  mep_pkg::cmd_t                   ctrl_cmd;
  mep_pkg::sts_t                   dp_sts;
  logic                            in_ready;
  logic                            out_free;
  logic [mep_pkg::COUNT_WIDTH-1:0] count;

  logic out_valid_q;

  // The output register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !in_ready;

  mep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .sts_i      (dp_sts),
    .in_ready_o (in_ready),
    .cmd_o      (ctrl_cmd)
  );

  mep_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .iter_limit_i (iter_limit_q),
    .bound_i      (bound_q),
    .c_real_i     (c_real_i),
    .c_imag_i     (c_imag_i),
    .sts_o        (dp_sts),
    .count_o      (count)
  );

  // Pixel formatting from the remaining count; in-set points carry count zero.
  logic [15:0] cnt16;
  logic [15:0] cprod;
  logic [7:0]  v;
  logic [7:0]  grey_d, red_d, green_d, blue_d;

  assign cnt16 = 16'(count);
  assign cprod = cnt16[7:0] * color_step_q;
  assign v     = cprod[7:0];

  always_comb begin
    grey_d  = '0;
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    case (mode_q)
      mep_pkg::MODE_BW: begin
        grey_d = {7'b0, ctrl_cmd.in_set};
      end
      mep_pkg::MODE_GREY: begin
        grey_d = cnt16[7:0];
      end
      mep_pkg::MODE_COLOR: begin
        if (!ctrl_cmd.in_set) begin
          red_d   = {v[6:0], 1'b0};
          green_d = v;
          blue_d  = v;
        end
      end
      default: ;
    endcase
  end

  // Output register: load on emit, drop valid once the transfer completes.
  logic [15:0] escape_count_q;
  logic        in_set_q;
  logic [7:0]  grey_q, red_q, green_q, blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd.emit) begin
      escape_count_q <= cnt16;
      in_set_q       <= ctrl_cmd.in_set;
      grey_q         <= grey_d;
      red_q          <= red_d;
      green_q        <= green_d;
      blue_q         <= blue_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = escape_count_q;
  assign in_set_o       = in_set_q;
  assign grey_o         = grey_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;

  // A transfer in must leave the block busy on the next cycle.
  `ASSERT_STD(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "missed stall")
  // An emitted result must show up as valid on the next cycle.
  `ASSERT_STD(a_emit_shows_valid, ctrl_cmd.emit |=> out_valid_o, "emitted result not valid")
  // A point in the set always reports a zero count.
  `ASSERT_STD(a_in_set_count_zero, out_valid_o && in_set_o |-> escape_count_o == '0, "set count")

endmodule

[test/mandelbrot_escape_pixel_tb.sv]
// Testbench for the escape-time pixel evaluator: directed and random points vs. a predictor.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_SEGMENTS = 4;
  localparam int POINTS_PER_SEGMENT = 106;

  // Q4.28 points used by the directed tests
  localparam logic [31:0] C_ZERO     = 32'h0000_0000;
  localparam logic [31:0] C_MIN      = 32'h8000_0000;
  localparam logic [31:0] C_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] C_ONE      = 32'h1000_0000;
  localparam logic [31:0] C_NEG_TWO  = 32'hE000_0000;
  localparam logic [31:0] C_QUARTER  = 32'h0400_0000;
  localparam logic [31:0] C_3QUARTER = 32'h0C00_0000;
  localparam logic [31:0] C_EIGHTH   = 32'h0200_0000;
  localparam logic [31:0] C_TENTH    = 32'h0199_999A;
  localparam logic [31:0] C_NEG_TENTH = 32'hFE66_6666;

  typedef struct packed {
    logic [15:0] count;
    logic        in_set;
    logic [7:0]  grey;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [mep_pkg::C_BITS-1:0] c_real_i = '0;
  logic signed [mep_pkg::C_BITS-1:0] c_imag_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] escape_count_o;
  logic in_set_o;
  logic [7:0] grey_o, red_o, green_o, blue_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mep_pkg::ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // register shadow used by the predictor
  logic [1:0]                      mode_q = mep_pkg::MODE_RESET;
  logic [mep_pkg::BOUND_BITS-1:0]  bound_q = mep_pkg::BOUND_RESET;
  logic [mep_pkg::COUNT_WIDTH-1:0] iter_limit_q = mep_pkg::ITER_LIMIT_RESET;
  logic [7:0]                      step_q = mep_pkg::COLOR_STEP_RESET;

  pixel_t pixel_q[$];
  int mismatches = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int stuck = 0;

  mandelbrot_escape_pixel dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .c_real_i(c_real_i),
    .c_imag_i(c_imag_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .escape_count_o(escape_count_o),
    .in_set_o(in_set_o),
    .grey_o(grey_o),
    .red_o(red_o),
    .green_o(green_o),
    .blue_o(blue_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Clamp a z part to the signed Z_BITS range.
  function automatic logic signed [127:0] clamp_z(input logic signed [127:0] v);
    logic signed [127:0] top;
    top = (128'sd1 <<< (mep_pkg::Z_BITS - 1)) - 128'sd1;
    if (v > top) return top;
    if (v < -top - 128'sd1) return -top - 128'sd1;
    return v;
  endfunction

  // Iterate z = z^2 + c from zero and format the pixel for the current mode.
  function automatic pixel_t escape_pixel(input logic [31:0] c_re, input logic [31:0] c_im);
    logic signed [127:0] cr, ci, zr, zi, re, im, mag;
    logic [mep_pkg::COUNT_WIDTH-1:0] left;
    logic escaped;
    logic [7:0] v;
    pixel_t px;
    // c and z share 28 fraction bits, so the point converts exactly
    cr = $signed(c_re);
    ci = $signed(c_im);
    zr = '0;
    zi = '0;
    left = iter_limit_q;
    escaped = 1'b0;
    while (left != 0 && !escaped) begin
      // magnitude test on |z|^2 floored to the bound's 27 fraction bits
      mag = (zr * zr + zi * zi) >>> (2 * mep_pkg::FRACTION_BITS - mep_pkg::BOUND_FRAC);
      if (mag >= bound_q) begin
        escaped = 1'b1;
      end else begin
        re = clamp_z((zr * zr - zi * zi) >>> mep_pkg::FRACTION_BITS);
        im = clamp_z((zr * zi) >>> (mep_pkg::FRACTION_BITS - 1));
        zr = clamp_z(re + cr);
        zi = clamp_z(im + ci);
        left = left - 1'b1;
      end
    end
    if (!escaped) left = '0;
    px = '0;
    px.count = left[15:0];
    px.in_set = !escaped;
    case (mode_q)
      mep_pkg::MODE_BW: px.grey = escaped ? 8'd0 : 8'd1;
      mep_pkg::MODE_GREY: px.grey = left[7:0];
      mep_pkg::MODE_COLOR: begin
        if (escaped) begin
          v = 8'(left[7:0] * step_q);
          px.red = {v[6:0], 1'b0};
          px.green = v;
          px.blue = v;
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  // Send one point; predict its pixel at the transfer.
  task automatic send_point(input logic [31:0] re, input logic [31:0] im);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    c_real_i <= re;
    c_imag_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    pixel_q.push_back(escape_pixel(re, im));
  endtask

  // Drop valid and wait for every predicted pixel to come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write one register, mirror it in the shadow, then read it back.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx)
      mep_pkg::REG_MODE: mask = 32'h0000_0003;
      mep_pkg::REG_BOUND: mask = 32'hFFFF_FFFF;
      mep_pkg::REG_ITER_LIMIT: mask = 32'h0000_FFFF;
      default: mask = 32'h0000_00FF;
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      mep_pkg::REG_MODE: mode_q = value[1:0];
      mep_pkg::REG_BOUND: bound_q = value;
      mep_pkg::REG_ITER_LIMIT: iter_limit_q = value[mep_pkg::COUNT_WIDTH-1:0];
      default: step_q = value[7:0];
    endcase
    // read setup follows the write access; psel stays high
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== (value & mask)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back %h, expected %h", idx, prdata, value & mask);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [1:0] mode, input logic [31:0] bound,
                           input logic [31:0] limit, input logic [31:0] step);
    write_reg(mep_pkg::REG_MODE, {30'd0, mode});
    write_reg(mep_pkg::REG_BOUND, bound);
    write_reg(mep_pkg::REG_ITER_LIMIT, limit);
    write_reg(mep_pkg::REG_COLOR_STEP, step);
  endtask

  // Reset defaults: greyscale, bound 4.0, limit 255, step 1.
  task automatic check_reset_defaults();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_point(C_ZERO, C_ZERO);
    send_point(C_NEG_TWO, C_ZERO);
    send_point(C_MIN, C_MIN);
    send_point(C_MAX, C_MAX);
    send_point(C_QUARTER, C_ZERO);
    wait_idle();
  endtask

  // Every mode, the unused one too, with an escaping and an in-set point.
  task automatic check_pixel_modes();
    logic [1:0] modes[4];
    modes = '{mep_pkg::MODE_BW, mep_pkg::MODE_GREY, mep_pkg::MODE_COLOR, MODE_UNUSED};
    src_idle_pct = 14;
    sink_stall_pct = 14;
    foreach (modes[k]) begin
      write_all(modes[k], mep_pkg::BOUND_RESET, 32'd20, 32'hB7);
      send_point(C_3QUARTER, C_EIGHTH);
      send_point(C_NEG_TENTH, C_TENTH);
      wait_idle();
    end
  endtask

  // Zero iteration limit: every point reports in set with count zero.
  task automatic check_zero_limit();
    src_idle_pct = 0;
    sink_stall_pct = 48;
    write_all(mep_pkg::MODE_COLOR, mep_pkg::BOUND_RESET, 32'd0, 32'd255);
    send_point(C_ZERO, C_ZERO);
    send_point(C_MAX, C_MIN);
    wait_idle();
  endtask

  // Zero bound escapes at once with the full count; largest bound next.
  task automatic check_bound_extremes();
    src_idle_pct = 48;
    sink_stall_pct = 0;
    write_all(mep_pkg::MODE_GREY, 32'd0, 32'hFFFF, 32'd0);
    send_point(C_ZERO, C_ZERO);
    send_point($urandom, $urandom);
    wait_idle();
    write_all(mep_pkg::MODE_COLOR, 32'hFFFF_FFFF, 32'd40, 32'd3);
    send_point(C_MIN, C_MIN);
    send_point(C_ONE, C_ZERO);
    send_point(C_ZERO, C_ZERO);
    wait_idle();
  endtask

  // Random segments: fresh settings, then points near the set plus raw noise.
  task automatic check_random_points(input int src_pct, input int sink_pct);
    logic [31:0] bound, limit, re, im;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
      case ($urandom_range(9))
        0: bound = 32'd0;
        1: bound = 32'hFFFF_FFFF;
        2, 3: bound = $urandom;
        4, 5, 6: bound = mep_pkg::BOUND_RESET;
        default: bound = $urandom_range(32'h4000_0000, 32'h0800_0000);
      endcase
      limit = ($urandom_range(15) == 0) ? 32'd0 : $urandom_range(40, 1);
      write_all(2'($urandom_range(3)), bound, limit, $urandom_range(255));
      for (int n = 0; n < POINTS_PER_SEGMENT; n++) begin
        if ($urandom_range(3) == 0) begin
          re = $urandom;
          im = $urandom;
        end else begin
          // window from -2.25 to 0.75 real, -1.5 to 1.5 imaginary
          re = $urandom_range(32'h3000_0000) - 32'h2400_0000;
          im = $urandom_range(32'h3000_0000) - 32'h1800_0000;
        end
        send_point(re, im);
      end
      wait_idle();
    end
  endtask

  // Output side: check each transfer against the oldest prediction, stall at random.
  always @(posedge clk_i) begin : check_results
    pixel_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {escape_count_o, in_set_o, grey_o, red_o, green_o, blue_o};
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: count %0d in_set %b grey %h rgb %h %h %h",
                   got.count, got.in_set, got.grey, got.red, got.green, got.blue);
      end else begin
        want = pixel_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch (got/expected): count %0d/%0d in_set %b/%b grey %h/%h",
                     got.count, want.count, got.in_set, want.in_set, got.grey, want.grey);
            $display("  red %h/%h green %h/%h blue %h/%h",
                     got.red, want.red, got.green, want.green, got.blue, want.blue);
          end
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog: count cycles without any transfer on either channel or the register port.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
      stuck <= 0;
    else
      stuck <= stuck + 1;
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reset_defaults();
    check_pixel_modes();
    check_zero_limit();
    check_bound_extremes();
    check_random_points(0, 0);
    check_random_points(48, 0);
    check_random_points(0, 48);
    check_random_points(14, 14);
    wait_idle();
    // hold a little longer to catch stray results
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pixel_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mep_pkg.sv
rtl/core/mep_ctrl.sv
rtl/core/mep_datapath.sv
rtl/core/mandelbrot_escape_pixel.sv
test/mandelbrot_escape_pixel_tb.sv
